>>> design/uprt_pkg.sv
package uprt_pkg;

	// command codes
	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_PACKET = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_BEGUN     = 3'd0;
	localparam logic [2:0] ST_REFUSED   = 3'd1;
	localparam logic [2:0] ST_STORED    = 3'd2;
	localparam logic [2:0] ST_REJECTED  = 3'd3;
	localparam logic [2:0] ST_DUPLICATE = 3'd4;
	localparam logic [2:0] ST_FAILED    = 3'd5;
	localparam logic [2:0] ST_CHECK     = 3'd6;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_BYTES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_SIZE_KB = 3'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] packet_id;
		logic [7:0]  payload_length;
		logic        write_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] flash_address;
		logic [10:0] missing_id;
		logic        all_received;
		logic [7:0]  error_total;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  packet_bytes;
		logic [11:0] packet_count;
		logic [31:0] image_base;
		logic [15:0] flash_size_kb;
	} cfg_t;

	// usable image space for each flash size class
	function automatic logic [17:0] usable_bytes(input logic [15:0] kb);
		logic [17:0] bytes;
		case (kb)
			16'd64:  bytes = 18'(31 * 32'h400);
			16'd128: bytes = 18'(47 * 32'h400);
			16'd256: bytes = 18'(100 * 32'h400);
			16'd512: bytes = 18'(200 * 32'h400);
			default: bytes = 18'd0;
		endcase
		return bytes;
	endfunction

	// position of the lowest set bit of a word
	function automatic logic [4:0] lowest_set(input logic [31:0] m);
		logic [4:0] pos;
		pos = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (m[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

endpackage

>>> design/uprt_ram.sv
module uprt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/uprt_ctrl.sv
module uprt_ctrl #(
	parameter int MAX_PACKETS  = 2048,
	parameter int MAX_PAYLOAD  = 200,
	parameter int MAX_REPORTED = 51
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  uprt_pkg::in_item_t item,
	input  uprt_pkg::cfg_t    cfg,
	output logic              result_valid,
	output uprt_pkg::result_t result
);

	localparam int MAP_WORDS = (MAX_PACKETS + 31) / 32;
	localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
	localparam int CNT_W     = $clog2(MAX_REPORTED + 1);
	localparam logic [16:0]       MAXP      = 17'(MAX_PACKETS);
	localparam logic [7:0]        MAXLEN    = 8'(MAX_PAYLOAD);
	localparam logic [CNT_W-1:0]  MAXREP    = CNT_W'(MAX_REPORTED);
	localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(MAP_WORDS - 1);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_CLEAR   = 9'b000000010,
		S_BEGIN   = 9'b000000100,
		S_PK_CHK  = 9'b000001000,
		S_PK_UPD  = 9'b000010000,
		S_CK_RD   = 9'b000100000,
		S_CK_LOAD = 9'b001000000,
		S_CK_BIT  = 9'b010000000,
		S_CK_FIN  = 9'b100000000
	} state_t;

	state_t             state_q;
	uprt_pkg::in_item_t item_q;
	logic [23:0]        prod_q;
	logic [WCNT_W-1:0]  clr_q;
	logic [WCNT_W-1:0]  w_q;
	logic [31:0]        mask_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pend_valid_q;
	logic [16:0]        pend_id_q;
	logic [7:0]         err_q;
	logic               valid_q;
	uprt_pkg::result_t  res_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0]       wdata;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       rdata;

	logic [ADDR_W-1:0] pk_word;
	logic [4:0]        pk_bit;
	logic              hit;
	logic              reject;
	logic              refuse;
	logic [19:0]       image_bytes;
	logic [16:0]       lim;
	logic [17:0]       lim_up;
	logic [WCNT_W-1:0] nwords;
	logic [16:0]       base;
	logic [16:0]       rem;
	logic [31:0]       lmask;
	logic [16:0]       id_found;
	logic [31:0]       addr;

	uprt_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// packet decode and checks
	assign pk_word = ADDR_W'(item_q.packet_id >> 5);
	assign pk_bit  = item_q.packet_id[4:0];
	assign hit     = rdata[pk_bit];
	assign reject  = ({1'b0, item_q.packet_id} >= {5'd0, cfg.packet_count})
		|| ({1'b0, item_q.packet_id} >= MAXP)
		|| (item_q.payload_length > MAXLEN);
	assign addr    = {8'd0, prod_q} + cfg.image_base;

	// begin check: alignment and image size against usable space
	assign image_bytes = 20'(cfg.packet_bytes * cfg.packet_count);
	assign refuse = (cfg.packet_bytes[1:0] != 2'b00)
		|| (image_bytes > {2'b00, uprt_pkg::usable_bytes(cfg.flash_size_kb)});

	// scan limits and mask of live bits in the current word
	assign lim      = ({5'd0, cfg.packet_count} > MAXP) ? MAXP : {5'd0, cfg.packet_count};
	assign lim_up   = {1'b0, lim} + 18'd31;
	assign nwords   = WCNT_W'(lim_up >> 5);
	assign base     = 17'(w_q) << 5;
	assign rem      = lim - base;
	assign lmask    = (rem >= 17'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << rem[4:0]);
	assign id_found = base | {12'd0, uprt_pkg::lowest_set(mask_q)};

	// bitmap port control
	always_comb begin
		we    = 1'b0;
		waddr = pk_word;
		wdata = rdata | (32'd1 << pk_bit);
		raddr = (state_q == S_CK_RD) ? ADDR_W'(w_q) : pk_word;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = ADDR_W'(clr_q);
				wdata = 32'd0;
			end
			S_PK_UPD: begin
				we = !hit && item_q.write_ok;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			w_q          <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			err_q        <= 8'd0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						w_q          <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
						case (item.command)
							uprt_pkg::CMD_BEGIN:  state_q <= S_BEGIN;
							uprt_pkg::CMD_PACKET: state_q <= S_PK_CHK;
							uprt_pkg::CMD_CHECK:  state_q <= S_CK_RD;
							default:              state_q <= S_IDLE;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_BEGIN: begin
					valid_q <= 1'b1;
					if (refuse) begin
						state_q <= S_IDLE;
					end else begin
						err_q   <= 8'd0;
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_PK_CHK: begin
					if (reject) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PK_UPD;
					end
				end
				S_PK_UPD: begin
					valid_q <= 1'b1;
					if (!hit && !item_q.write_ok) begin
						err_q <= err_q + 8'd1;
					end
					state_q <= S_IDLE;
				end
				S_CK_RD: begin
					state_q <= (w_q == nwords) ? S_CK_FIN : S_CK_LOAD;
				end
				S_CK_LOAD: begin
					state_q <= S_CK_BIT;
				end
				S_CK_BIT: begin
					if (mask_q == 32'd0) begin
						w_q     <= w_q + 1'b1;
						state_q <= S_CK_RD;
					end else begin
						valid_q      <= pend_valid_q;
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_q + 1'b1;
						if (cnt_q + 1'b1 == MAXREP) begin
							state_q <= S_CK_FIN;
						end
					end
				end
				S_CK_FIN: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item, product, scan word and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == S_PK_CHK) begin
			prod_q <= item_q.packet_id * cfg.packet_bytes;
		end
		if (state_q == S_CK_LOAD) begin
			mask_q <= ~rdata & lmask;
		end else if (state_q == S_CK_BIT && mask_q != 32'd0) begin
			mask_q    <= mask_q & (mask_q - 32'd1);
			pend_id_q <= id_found;
		end

		res_q.flash_address <= 32'd0;
		res_q.missing_id    <= 11'd0;
		res_q.all_received  <= 1'b0;
		res_q.error_total   <= err_q;
		res_q.last          <= 1'b1;
		res_q.status        <= uprt_pkg::ST_CHECK;
		case (state_q)
			S_BEGIN: begin
				res_q.status      <= refuse ? uprt_pkg::ST_REFUSED : uprt_pkg::ST_BEGUN;
				res_q.error_total <= refuse ? err_q : 8'd0;
			end
			S_PK_CHK: begin
				res_q.status <= uprt_pkg::ST_REJECTED;
			end
			S_PK_UPD: begin
				if (hit) begin
					res_q.status <= uprt_pkg::ST_DUPLICATE;
				end else if (item_q.write_ok) begin
					res_q.status        <= uprt_pkg::ST_STORED;
					res_q.flash_address <= addr;
				end else begin
					res_q.status        <= uprt_pkg::ST_FAILED;
					res_q.flash_address <= addr;
					res_q.error_total   <= err_q + 8'd1;
				end
			end
			S_CK_BIT: begin
				res_q.missing_id <= pend_id_q[10:0];
				res_q.last       <= 1'b0;
			end
			S_CK_FIN: begin
				res_q.missing_id   <= pend_valid_q ? pend_id_q[10:0] : 11'd0;
				res_q.all_received <= !pend_valid_q;
			end
			default: begin
				res_q.last <= 1'b1;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

>>> design/update_packet_receipt_tracker.sv
// Firmware-update packet receipt tracker.
// Input channel: an item (command, packet_id, payload_length, write_ok) is taken
// at a clock edge with start high and busy low. Results leave on result with
// result_valid high for one cycle each; the receiver takes every result and
// cannot hold them off. The last result of an item carries last = 1.
// Configuration: cfg_index / cfg_data written when cfg_valid is high (cfg_ready
// is always high); indexes beyond the register list are ignored.
// Sequence of each command (busy stays high until it is done):
//   packet: one bitmap word read, then its read-modify-write unless rejected
//   begin:  result only if refused, else result then the bitmap clear sweep
//           (one word per cycle; MAP_WORDS = ceil(MAX_PACKETS / 32) words)
//   check:  each bitmap word is read, loaded and searched bit by bit; missing
//           ids are reported one result each, then a final result closes the
//           scan; the report limit can end the scan early
//   an unused command code yields no result and leaves busy low
// Reset: the control and configuration registers clear and the bitmap is
// swept to zero, one word a cycle, while busy stays high.
module update_packet_receipt_tracker #(
	parameter int MAX_PACKETS  = 2048,
	parameter int MAX_PAYLOAD  = 200,
	parameter int MAX_REPORTED = 51
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  uprt_pkg::in_item_t                   item,
	output logic                                 result_valid,
	output uprt_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [uprt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data
);

	uprt_pkg::cfg_t cfg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				uprt_pkg::REG_PACKET_BYTES:  cfg_q.packet_bytes  <= cfg_data[7:0];
				uprt_pkg::REG_PACKET_COUNT:  cfg_q.packet_count  <= cfg_data[11:0];
				uprt_pkg::REG_IMAGE_BASE:    cfg_q.image_base    <= cfg_data;
				uprt_pkg::REG_FLASH_SIZE_KB: cfg_q.flash_size_kb <= cfg_data[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	uprt_ctrl #(
		.MAX_PACKETS  (MAX_PACKETS),
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.MAX_REPORTED (MAX_REPORTED)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
